// ----- hdl/ipsv_pkg.sv -----
`default_nettype none
package ipsv_pkg;

	localparam int VOLT_W     = 19;
	localparam int TRIG_W     = 14;
	localparam int PER_W      = 16;
	localparam int BUS_W      = 6;
	localparam int LIM_W      = 16;
	localparam int SEC_W      = 3;
	localparam int TIME_W     = 18;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam int M32_W = 17;
	localparam int USQ_W = 12;
	localparam int THR_W = 31;

	localparam logic [CFG_IDX_W-1:0] REG_PWM_PERIOD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BUS_VOLTAGE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT  = 2'd2;

	localparam logic [PER_W-1:0] PERIOD_RESET = 16'd1480;
	localparam logic [BUS_W-1:0] BUS_RESET    = 6'd12;
	localparam logic [LIM_W-1:0] LIMIT_RESET  = 16'd1480;

	localparam int K_SQRT3 = 3547;
	localparam int K_HALF  = 2048;
	localparam int K_TS    = 1774;
	localparam int THR_NUM = 33;
	localparam int THR_DEN = 100;
	localparam int ROT_SH  = 12;
	localparam int MAG_SH  = 14;
	localparam int M32_SH  = 10;

	localparam logic [M32_W-1:0] M32_RESET =
		M32_W'((K_TS * int'(PERIOD_RESET) / int'(BUS_RESET)) >> M32_SH);
	localparam logic [USQ_W-1:0] USQ_RESET = USQ_W'(int'(BUS_RESET) * int'(BUS_RESET));
	localparam logic [THR_W-1:0] THR_RESET =
		THR_W'((THR_NUM * int'(BUS_RESET) * int'(BUS_RESET)) << MAG_SH);

	typedef struct packed {
		logic             start;
		logic [PER_W-1:0] period;
		logic [BUS_W-1:0] bus;
	} scale_req_t;

	typedef struct packed {
		logic             busy;
		logic [M32_W-1:0] m32;
		logic [USQ_W-1:0] udc_sq;
		logic [THR_W-1:0] thr;
	} scale_sts_t;

endpackage
`default_nettype wire

// ----- hdl/ipsv_intf.sv -----
`default_nettype none
interface ipsv_vec_if;
	logic                                valid;
	logic                                ready;
	logic signed [ipsv_pkg::VOLT_W-1:0] volt_d;
	logic signed [ipsv_pkg::VOLT_W-1:0] volt_q;
	logic signed [ipsv_pkg::TRIG_W-1:0] sine_val;
	logic signed [ipsv_pkg::TRIG_W-1:0] cosine_val;
	modport source (output valid, volt_d, volt_q, sine_val, cosine_val, input ready);
	modport sink (input valid, volt_d, volt_q, sine_val, cosine_val, output ready);
endinterface

interface ipsv_res_if;
	logic                                valid;
	logic                                ready;
	logic        [ipsv_pkg::SEC_W-1:0]  sector;
	logic signed [ipsv_pkg::TIME_W-1:0] phase_a_time;
	logic signed [ipsv_pkg::TIME_W-1:0] phase_b_time;
	logic signed [ipsv_pkg::TIME_W-1:0] phase_c_time;
	logic                                magnitude_limited;
	modport source (output valid, sector, phase_a_time, phase_b_time, phase_c_time,
		magnitude_limited, input ready);
	modport sink (input valid, sector, phase_a_time, phase_b_time, phase_c_time,
		magnitude_limited, output ready);
endinterface

interface ipsv_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [ipsv_pkg::CFG_IDX_W-1:0]     index;
	logic [ipsv_pkg::CFG_DATA_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- hdl/ipsv_scale.sv -----
`default_nettype none
module ipsv_scale (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire ipsv_pkg::scale_req_t req,
	output ipsv_pkg::scale_sts_t      sts
);

	typedef enum logic {ST_IDLE, ST_RUN} state_t;

	state_t                         state_q;
	logic [4:0]                     cnt_q;
	logic [ipsv_pkg::BUS_W-1:0]     bus_q;
	logic [ipsv_pkg::BUS_W-1:0]     rem_q;
	logic [26:0]                    num_q;
	logic [26:0]                    quo_q;
	logic [ipsv_pkg::M32_W-1:0]     m32_q;
	logic [ipsv_pkg::USQ_W-1:0]     usq_q;
	logic [ipsv_pkg::THR_W-1:0]     thr_q;

	logic [ipsv_pkg::BUS_W:0]       trial;
	logic                           qbit;
	logic [ipsv_pkg::USQ_W-1:0]     usq_new;

	always_comb begin
		trial   = {rem_q, num_q[26]};
		qbit    = trial >= {1'b0, bus_q};
		usq_new = ipsv_pkg::USQ_W'(req.bus) * ipsv_pkg::USQ_W'(req.bus);
	end

	// one quotient bit of 1774*period/bus per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			bus_q   <= '0;
			rem_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			m32_q   <= ipsv_pkg::M32_RESET;
			usq_q   <= ipsv_pkg::USQ_RESET;
			thr_q   <= ipsv_pkg::THR_RESET;
		end else if (req.start) begin
			state_q <= ST_RUN;
			cnt_q   <= 5'd26;
			bus_q   <= req.bus;
			rem_q   <= '0;
			num_q   <= 27'(ipsv_pkg::K_TS) * 27'(req.period);
			quo_q   <= '0;
			usq_q   <= usq_new;
			thr_q   <= (ipsv_pkg::THR_W'(usq_new) * ipsv_pkg::THR_W'(ipsv_pkg::THR_NUM))
				<< ipsv_pkg::MAG_SH;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
				end
				ST_RUN: begin
					rem_q <= qbit ? ipsv_pkg::BUS_W'(trial - {1'b0, bus_q})
						: trial[ipsv_pkg::BUS_W-1:0];
					num_q <= {num_q[25:0], 1'b0};
					quo_q <= {quo_q[25:0], qbit};
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) begin
						state_q <= ST_IDLE;
						m32_q   <= (bus_q == '0) ? '0 : quo_q[25:9];
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign sts.busy   = state_q == ST_RUN;
	assign sts.m32    = m32_q;
	assign sts.udc_sq = usq_q;
	assign sts.thr    = thr_q;

endmodule
`default_nettype wire

// ----- hdl/inverse_park_svpwm_timing.sv -----
`default_nettype none
// channel   dir  payload                                           beat when
// vec_in    in   volt_d volt_q sine_val cosine_val                 valid && ready
// vec_out   out  sector phase_a/b/c_time magnitude_limited         valid && ready
// cfg       in   index data                                        valid && ready
//
// one item per cycle while vec_out takes results and no period factor is being formed;
// two pipelined restoring dividers (10 and 16 stages, one quotient bit per stage)
// a write to pwm_period or bus_voltage holds vec_in.ready low
// while a serial divider forms the period factor, one bit per cycle
// reset clears the valid bits and loads the register defaults
// a stall at vec_out freezes the whole pipe in place
module inverse_park_svpwm_timing (
	input wire logic  clk,
	input wire logic  arst_n,
	ipsv_vec_if.sink  vec_in,
	ipsv_res_if.source vec_out,
	ipsv_cfg_if.sink  cfg
);

	localparam int MQ = 10;
	localparam int TQ = 16;

	typedef struct packed {
		logic               lim;
		logic               neg_a;
		logic               neg_b;
		logic [27:0]        mag;
		logic [32:0]        rem_a;
		logic [32:0]        rem_b;
		logic [MQ-1:0]      q_a;
		logic [MQ-1:0]      q_b;
		logic signed [21:0] alpha;
		logic signed [21:0] beta;
	} mdiv_t;

	typedef struct packed {
		logic        lim;
		logic [2:0]  sector;
		logic        over;
		logic [24:0] tx;
		logic [24:0] ty;
		logic [25:0] sum;
		logic [40:0] rem_x;
		logic [40:0] rem_y;
		logic [TQ-1:0] q_x;
		logic [TQ-1:0] q_y;
	} tdiv_t;

	function automatic mdiv_t mstep(input mdiv_t s, input int sh);
		mdiv_t       r;
		logic [37:0] d;
		r     = s;
		d     = 38'(s.mag) << sh;
		r.q_a = {s.q_a[MQ-2:0], 1'b0};
		r.q_b = {s.q_b[MQ-2:0], 1'b0};
		if (38'(s.rem_a) >= d) begin
			r.rem_a  = s.rem_a - d[32:0];
			r.q_a[0] = 1'b1;
		end
		if (38'(s.rem_b) >= d) begin
			r.rem_b  = s.rem_b - d[32:0];
			r.q_b[0] = 1'b1;
		end
		return r;
	endfunction

	function automatic tdiv_t tstep(input tdiv_t s, input int sh);
		tdiv_t       r;
		logic [41:0] d;
		r     = s;
		d     = 42'(s.sum) << sh;
		r.q_x = {s.q_x[TQ-2:0], 1'b0};
		r.q_y = {s.q_y[TQ-2:0], 1'b0};
		if (42'(s.rem_x) >= d) begin
			r.rem_x  = s.rem_x - d[40:0];
			r.q_x[0] = 1'b1;
		end
		if (42'(s.rem_y) >= d) begin
			r.rem_y  = s.rem_y - d[40:0];
			r.q_y[0] = 1'b1;
		end
		return r;
	endfunction

	// configuration
	logic [ipsv_pkg::PER_W-1:0] ts_q;
	logic [ipsv_pkg::BUS_W-1:0] udc_q;
	logic [ipsv_pkg::LIM_W-1:0] lim_q;
	logic                       start_q;
	ipsv_pkg::scale_req_t       req;
	ipsv_pkg::scale_sts_t       sts;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q    <= ipsv_pkg::PERIOD_RESET;
			udc_q   <= ipsv_pkg::BUS_RESET;
			lim_q   <= ipsv_pkg::LIMIT_RESET;
			start_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (cfg.valid) begin
				unique case (cfg.index)
					ipsv_pkg::REG_PWM_PERIOD: begin
						ts_q    <= cfg.data;
						start_q <= 1'b1;
					end
					ipsv_pkg::REG_BUS_VOLTAGE: begin
						udc_q   <= cfg.data[ipsv_pkg::BUS_W-1:0];
						start_q <= 1'b1;
					end
					ipsv_pkg::REG_TIME_LIMIT: lim_q <= cfg.data;
					default: begin
					end
				endcase
			end
		end
	end

	assign req.start  = start_q;
	assign req.period = ts_q;
	assign req.bus    = udc_q;

	ipsv_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.sts    (sts)
	);

	// pipeline control
	logic en;
	logic busy;
	logic v_s1, v_s2, v_s3, v_s4, v_s16, v_s17, v_s18, v_s19, v_s37;
	logic mv_s5 [0:MQ];
	logic tv_s20 [0:TQ];

	assign busy         = start_q || sts.busy;
	assign en           = !v_s37 || vec_out.ready;
	assign vec_in.ready = en && !busy;

	// payload
	logic signed [32:0] pdc_s1, pqs_s1, pds_s1, pqc_s1;
	logic signed [21:0] alpha_s2, beta_s2, alpha_s3, beta_s3, alpha_s4, beta_s4;
	logic [40:0]        sqa_s3, sqb_s3;
	logic [27:0]        mag_s4;
	mdiv_t              md_s5 [0:MQ];
	mdiv_t              md_in;
	logic signed [34:0] ka_s16;
	logic signed [21:0] b2_s16;
	logic               lim_s16, lim_s17, lim_s18, lim_s19;
	logic signed [22:0] u1_s17, u2_s17, u3_s17;
	logic [2:0]         sec_s18, sec_s19;
	logic [22:0]        opx_s18, opy_s18;
	logic [24:0]        tx_s19, ty_s19;
	tdiv_t              td_s20 [0:TQ];
	tdiv_t              td_in;
	logic [ipsv_pkg::SEC_W-1:0]         sec_s37;
	logic signed [ipsv_pkg::TIME_W-1:0] ta_s37, tb_s37, tc_s37;
	logic                               lim_s37;

	logic signed [21:0] abs_a, abs_b, a2, b2;
	logic signed [34:0] bb;
	logic [2:0]         code;
	logic [2:0]         sec_n;
	logic [22:0]        opx_n, opy_n;
	logic [24:0]        fx, fy;
	logic signed [27:0] tsx, fxs, fys, pp, mp, mm;
	logic signed [ipsv_pkg::TIME_W-1:0] ta_n, tb_n, tc_n;
	mdiv_t              mq;
	tdiv_t              tq;

	always_comb begin
		abs_a       = alpha_s4[21] ? -alpha_s4 : alpha_s4;
		abs_b       = beta_s4[21] ? -beta_s4 : beta_s4;
		md_in       = '0;
		md_in.lim   = (35'(mag_s4) * 35'(ipsv_pkg::THR_DEN)) > 35'(sts.thr);
		md_in.neg_a = alpha_s4[21];
		md_in.neg_b = beta_s4[21];
		md_in.mag   = mag_s4;
		md_in.rem_a = 33'(abs_a[20:0]) * 33'(sts.udc_sq);
		md_in.rem_b = 33'(abs_b[20:0]) * 33'(sts.udc_sq);
		md_in.alpha = alpha_s4;
		md_in.beta  = beta_s4;

		mq = md_s5[MQ];
		if (mq.lim) begin
			a2 = mq.neg_a ? -$signed(22'(mq.q_a)) : $signed(22'(mq.q_a));
			b2 = mq.neg_b ? -$signed(22'(mq.q_b)) : $signed(22'(mq.q_b));
		end else begin
			a2 = mq.alpha;
			b2 = mq.beta;
		end

		bb = 35'(b2_s16) * 35'(ipsv_pkg::K_HALF);

		code  = {u3_s17 > 23'sd0, u2_s17 > 23'sd0, u1_s17 > 23'sd0};
		sec_n = 3'd0;
		opx_n = '0;
		opy_n = '0;
		unique case (code)
			3'd1: begin sec_n = 3'd2; opx_n = 23'(-u2_s17); opy_n = 23'(-u3_s17); end
			3'd2: begin sec_n = 3'd6; opx_n = 23'(-u3_s17); opy_n = 23'(-u1_s17); end
			3'd3: begin sec_n = 3'd1; opx_n = 23'(u2_s17);  opy_n = 23'(u1_s17);  end
			3'd4: begin sec_n = 3'd4; opx_n = 23'(-u1_s17); opy_n = 23'(-u2_s17); end
			3'd5: begin sec_n = 3'd3; opx_n = 23'(u1_s17);  opy_n = 23'(u3_s17);  end
			3'd6: begin sec_n = 3'd5; opx_n = 23'(u3_s17);  opy_n = 23'(u2_s17);  end
			default: begin
			end
		endcase

		td_in        = '0;
		td_in.lim    = lim_s19;
		td_in.sector = sec_s19;
		td_in.tx     = tx_s19;
		td_in.ty     = ty_s19;
		td_in.sum    = 26'(tx_s19) + 26'(ty_s19);
		td_in.over   = td_in.sum > 26'(lim_q);
		td_in.rem_x  = 41'(tx_s19) * 41'(lim_q);
		td_in.rem_y  = 41'(ty_s19) * 41'(lim_q);

		tq  = td_s20[TQ];
		fx  = tq.over ? 25'(tq.q_x) : tq.tx;
		fy  = tq.over ? 25'(tq.q_y) : tq.ty;
		tsx = 28'(ts_q);
		fxs = 28'(fx);
		fys = 28'(fy);
		pp  = (tsx + fxs + fys) >>> 1;
		mp  = (tsx - fxs + fys) >>> 1;
		mm  = (tsx - fxs - fys) >>> 1;
		ta_n = '0;
		tb_n = '0;
		tc_n = '0;
		unique case (tq.sector)
			3'd1: begin ta_n = 18'(pp); tb_n = 18'(mp); tc_n = 18'(mm); end
			3'd2: begin ta_n = 18'(mp); tb_n = 18'(pp); tc_n = 18'(mm); end
			3'd3: begin ta_n = 18'(mm); tb_n = 18'(pp); tc_n = 18'(mp); end
			3'd4: begin ta_n = 18'(mm); tb_n = 18'(mp); tc_n = 18'(pp); end
			3'd5: begin ta_n = 18'(mp); tb_n = 18'(mm); tc_n = 18'(pp); end
			3'd6: begin ta_n = 18'(pp); tb_n = 18'(mm); tc_n = 18'(mp); end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// rotation products
			pdc_s1 <= 33'(vec_in.volt_d) * 33'(vec_in.cosine_val);
			pqs_s1 <= 33'(vec_in.volt_q) * 33'(vec_in.sine_val);
			pds_s1 <= 33'(vec_in.volt_d) * 33'(vec_in.sine_val);
			pqc_s1 <= 33'(vec_in.volt_q) * 33'(vec_in.cosine_val);

			alpha_s2 <= 22'((34'(pdc_s1) - 34'(pqs_s1)) >>> ipsv_pkg::ROT_SH);
			beta_s2  <= 22'((34'(pds_s1) + 34'(pqc_s1)) >>> ipsv_pkg::ROT_SH);

			sqa_s3   <= 41'(44'(alpha_s2) * 44'(alpha_s2));
			sqb_s3   <= 41'(44'(beta_s2) * 44'(beta_s2));
			alpha_s3 <= alpha_s2;
			beta_s3  <= beta_s2;

			mag_s4   <= 28'((42'(sqa_s3) + 42'(sqb_s3)) >> ipsv_pkg::MAG_SH);
			alpha_s4 <= alpha_s3;
			beta_s4  <= beta_s3;

			// magnitude scaling divider
			md_s5[0] <= md_in;
			for (int j = 0; j < MQ; j++) begin
				md_s5[j+1] <= mstep(md_s5[j], MQ - 1 - j);
			end

			ka_s16  <= 35'(a2) * 35'(ipsv_pkg::K_SQRT3);
			b2_s16  <= b2;
			lim_s16 <= mq.lim;

			u1_s17  <= 23'(b2_s16);
			u2_s17  <= 23'((ka_s16 - bb) >>> ipsv_pkg::ROT_SH);
			u3_s17  <= 23'((-ka_s16 - bb) >>> ipsv_pkg::ROT_SH);
			lim_s17 <= lim_s16;

			sec_s18 <= sec_n;
			opx_s18 <= opx_n;
			opy_s18 <= opy_n;
			lim_s18 <= lim_s17;

			tx_s19  <= 25'((40'(opx_s18) * 40'(sts.m32)) >> ipsv_pkg::MAG_SH);
			ty_s19  <= 25'((40'(opy_s18) * 40'(sts.m32)) >> ipsv_pkg::MAG_SH);
			sec_s19 <= sec_s18;
			lim_s19 <= lim_s18;

			// time limit divider
			td_s20[0] <= td_in;
			for (int j = 0; j < TQ; j++) begin
				td_s20[j+1] <= tstep(td_s20[j], TQ - 1 - j);
			end

			sec_s37 <= tq.sector;
			ta_s37  <= ta_n;
			tb_s37  <= tb_n;
			tc_s37  <= tc_n;
			lim_s37 <= tq.lim;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s16 <= 1'b0;
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
			v_s19 <= 1'b0;
			v_s37 <= 1'b0;
			for (int j = 0; j <= MQ; j++) mv_s5[j] <= 1'b0;
			for (int j = 0; j <= TQ; j++) tv_s20[j] <= 1'b0;
		end else if (en) begin
			v_s1     <= vec_in.valid && !busy;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			v_s4     <= v_s3;
			mv_s5[0] <= v_s4;
			for (int j = 0; j < MQ; j++) mv_s5[j+1] <= mv_s5[j];
			v_s16     <= mv_s5[MQ];
			v_s17     <= v_s16;
			v_s18     <= v_s17;
			v_s19     <= v_s18;
			tv_s20[0] <= v_s19;
			for (int j = 0; j < TQ; j++) tv_s20[j+1] <= tv_s20[j];
			v_s37 <= tv_s20[TQ];
		end
	end

	assign vec_out.valid             = v_s37;
	assign vec_out.sector            = sec_s37;
	assign vec_out.phase_a_time      = ta_s37;
	assign vec_out.phase_b_time      = tb_s37;
	assign vec_out.phase_c_time      = tc_s37;
	assign vec_out.magnitude_limited = lim_s37;

	a_busy_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !vec_in.ready)
		else $error("input beat taken while period factor is being formed");

	a_pipe_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(en && tv_s20[TQ]) |=> vec_out.valid)
		else $error("item lost at the output stage");

	a_limit_nonzero_mag: assert property (@(posedge clk) disable iff (!arst_n)
		(mv_s5[0] && md_s5[0].lim) |-> md_s5[0].mag != '0)
		else $error("magnitude scaling with zero divisor");

	a_sector_range: assert property (@(posedge clk) disable iff (!arst_n)
		vec_out.valid |-> vec_out.sector != 3'd7)
		else $error("sector out of range");

	a_no_sector_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(vec_out.valid && vec_out.sector == 3'd0) |-> (vec_out.phase_a_time == '0
		&& vec_out.phase_b_time == '0 && vec_out.phase_c_time == '0))
		else $error("nonzero compare times without a sector");

endmodule
`default_nettype wire
